// File: hw/rtl/adri_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adri_pkg
// Shared widths, codes and control types of the dead-reckoning integrator.
// ----------------------------------------------------------------------------
package adri_pkg;

    localparam int CAL_SAMPLES_DEF = 20;
    localparam int POS_SHIFT_DEF   = 20;

    localparam int ACC_W      = 16;
    localparam int T_W        = 32;
    localparam int POS_W      = 48;
    localparam int BSUM_W     = 22;
    localparam int CNT_W      = 7;
    localparam int AD_W       = 49;
    localparam int MUL_A_W    = 25;
    localparam int PROD_W     = 58;
    localparam int WIDE_W     = 84;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DZ_W       = 15;
    localparam int IDLE_W     = 29;

    // item function codes
    localparam logic [1:0] FUNC_CAL    = 2'd0;
    localparam logic [1:0] FUNC_MOTION = 2'd1;
    localparam logic [1:0] FUNC_SOFT   = 2'd2;
    localparam logic [1:0] FUNC_FULL   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH_TO = 2'd2;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE     = 4'd0;
    localparam op_t OP_LATCH    = 4'd1;
    localparam op_t OP_CAL_ADD  = 4'd2;
    localparam op_t OP_DIV_INIT = 4'd3;
    localparam op_t OP_DIV_STEP = 4'd4;
    localparam op_t OP_DIV_DONE = 4'd5;
    localparam op_t OP_FIRST    = 4'd6;
    localparam op_t OP_CLEAR    = 4'd7;
    localparam op_t OP_MUL_AD   = 4'd8;
    localparam op_t OP_VEL      = 4'd9;
    localparam op_t OP_K_HI     = 4'd10;
    localparam op_t OP_V_LO     = 4'd11;
    localparam op_t OP_V_HI     = 4'd12;
    localparam op_t OP_TERMS    = 4'd13;
    localparam op_t OP_ACCUM    = 4'd14;
    localparam op_t OP_LOAD_OUT = 4'd15;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       awaiting;
        logic       cal_full;
        logic       cal_last;
        logic       out_free;
    } status_t;

endpackage

// File: hw/rtl/adri_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adri_in_if
// Sample channel: valid/ready with one acceleration item per beat.
// ----------------------------------------------------------------------------
interface adri_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic [31:0]       time_us;

    modport source (output valid, func, acc_x, acc_y, acc_z, time_us, input ready);
    modport sink   (input valid, func, acc_x, acc_y, acc_z, time_us, output ready);
endinterface

// File: hw/rtl/adri_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adri_out_if
// Result channel: valid/ready with positions and status flags per beat.
// ----------------------------------------------------------------------------
interface adri_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] pos_vel_x;
    logic signed [47:0] pos_vel_y;
    logic signed [47:0] pos_vel_z;
    logic signed [47:0] pos_kin_x;
    logic signed [47:0] pos_kin_y;
    logic signed [47:0] pos_kin_z;
    logic               all_axes_idle;
    logic               recording_done;
    logic               is_calibrated;

    modport source (output valid, pos_vel_x, pos_vel_y, pos_vel_z, pos_kin_x, pos_kin_y,
                    pos_kin_z, all_axes_idle, recording_done, is_calibrated, input ready);
    modport sink   (input valid, pos_vel_x, pos_vel_y, pos_vel_z, pos_kin_x, pos_kin_y,
                    pos_kin_z, all_axes_idle, recording_done, is_calibrated, output ready);
endinterface

// File: hw/rtl/adri_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adri_datapath
// Calibration, shared axis integrator with one multiplier, result register.
// ----------------------------------------------------------------------------
module adri_datapath
    import adri_pkg::*;
#(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF,
    parameter int POS_SHIFT   = POS_SHIFT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [1:0]             func,
    input  logic signed [ACC_W-1:0] acc_x,
    input  logic signed [ACC_W-1:0] acc_y,
    input  logic signed [ACC_W-1:0] acc_z,
    input  logic [T_W-1:0]         time_us,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic signed [POS_W-1:0] pos_vel_x,
    output logic signed [POS_W-1:0] pos_vel_y,
    output logic signed [POS_W-1:0] pos_vel_z,
    output logic signed [POS_W-1:0] pos_kin_x,
    output logic signed [POS_W-1:0] pos_kin_y,
    output logic signed [POS_W-1:0] pos_kin_z,
    output logic                   all_axes_idle,
    output logic                   recording_done,
    output logic                   is_calibrated
);

    localparam logic [CNT_W-1:0] CAL_N = CNT_W'(CAL_SAMPLES);

    // bias mean by reciprocal multiply: exact quotient, truncated toward zero, for any sum magnitude
    localparam int DIV_S   = BSUM_W + $clog2(CAL_SAMPLES);
    localparam int RECIP_W = BSUM_W + 2;
    localparam int QP_W    = BSUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_S) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    function automatic logic signed [POS_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] x);
        logic [WIDE_W-POS_W:0] top;
        top = x[WIDE_W-1:POS_W-1];
        if (&top || ~|top)
            return x[POS_W-1:0];
        return x[WIDE_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    endfunction

    function automatic logic signed [POS_W-1:0] sat50(input logic signed [POS_W+1:0] x);
        logic [2:0] top;
        top = x[POS_W+1:POS_W-1];
        if (&top || ~|top)
            return x[POS_W-1:0];
        return x[POS_W+1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    endfunction

    // configuration
    logic [DZ_W-1:0]   dead_zone_reg;
    logic [IDLE_W-1:0] idle_to_reg;
    logic [T_W-1:0]    finish_to_reg;

    // item latch
    logic [1:0]              func_reg;
    logic signed [ACC_W-1:0] acc_reg [3];
    logic [T_W-1:0]          t_reg;
    logic [T_W-1:0]          dt_reg;

    // block state
    logic                    awaiting_reg;
    logic [T_W-1:0]          prev_time_reg;
    logic [T_W-1:0]          aat_reg [3];
    logic [T_W-1:0]          any_time_reg;
    logic signed [POS_W-1:0] vel_reg [3];
    logic signed [POS_W-1:0] pv_reg [3];
    logic signed [POS_W-1:0] pk_reg [3];
    logic signed [BSUM_W-1:0] bsum_reg [3];
    logic signed [ACC_W-1:0] bmean_reg [3];
    logic [CNT_W-1:0]        cal_count_reg;
    logic                    calibrated_reg;

    // divider
    logic [BSUM_W-1:0] num_reg [3];
    logic [QP_W-1:0]   qprod_reg [3];
    logic              neg_reg [3];

    // axis working registers
    logic signed [AD_W-1:0]   ad_reg;
    logic                     anz_reg;
    logic signed [POS_W-1:0]  vn_reg;
    logic signed [WIDE_W-1:0] kacc_reg;
    logic signed [WIDE_W-1:0] vacc_reg;
    logic signed [POS_W-1:0]  t1_reg;
    logic signed [POS_W-1:0]  t2_reg;

    logic out_valid_reg;

    // axis selection
    logic signed [ACC_W-1:0] acc_sel, bm_sel;
    logic signed [ACC_W:0]   a_full, mag, a_eff;
    logic [T_W-1:0]          aat_sel;
    logic signed [POS_W-1:0] vel_sel, pv_sel, pk_sel;

    assign acc_sel = acc_reg[cmd.axis];
    assign bm_sel  = bmean_reg[cmd.axis];
    assign aat_sel = aat_reg[cmd.axis];
    assign vel_sel = vel_reg[cmd.axis];
    assign pv_sel  = pv_reg[cmd.axis];
    assign pk_sel  = pk_reg[cmd.axis];

    assign a_full = {acc_sel[ACC_W-1], acc_sel} - {bm_sel[ACC_W-1], bm_sel};
    assign mag    = a_full[ACC_W] ? -a_full : a_full;
    assign a_eff  = ($unsigned(mag) < {2'b00, dead_zone_reg}) ? '0 : a_full;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [T_W:0]       dt_s;
    logic signed [PROD_W-1:0]  prod;
    logic signed [WIDE_W-1:0]  prod_w;

    always_comb
    begin
        case (cmd.op)
            OP_MUL_AD: mul_a = {{(MUL_A_W-ACC_W-1){a_eff[ACC_W]}}, a_eff};
            OP_VEL:    mul_a = {1'b0, ad_reg[23:0]};
            OP_K_HI:   mul_a = ad_reg[AD_W-1:24];
            OP_V_LO:   mul_a = {1'b0, vn_reg[23:0]};
            OP_V_HI:   mul_a = {vn_reg[POS_W-1], vn_reg[POS_W-1:24]};
            default:   mul_a = '0;
        endcase
    end

    assign dt_s   = {1'b0, dt_reg};
    assign prod   = mul_a * dt_s;
    assign prod_w = {{(WIDE_W-PROD_W){prod[PROD_W-1]}}, prod};

    logic signed [WIDE_W-1:0] ksum;
    assign ksum = kacc_reg + (vacc_reg <<< 1);

    logic signed [POS_W+1:0] vsum, pvsum, pksum;
    assign vsum  = {{2{vel_sel[POS_W-1]}}, vel_sel} + {ad_reg[AD_W-1], ad_reg};
    assign pvsum = {{2{pv_sel[POS_W-1]}}, pv_sel} + {{2{t1_reg[POS_W-1]}}, t1_reg};
    assign pksum = {{2{pk_sel[POS_W-1]}}, pk_sel} + {{2{t2_reg[POS_W-1]}}, t2_reg};

    logic [T_W-1:0] since_active;
    assign since_active = t_reg - aat_sel;

    // result flags
    logic [T_W:0] lim;
    logic [2:0]   ax_idle;
    logic [T_W-1:0] since_any;
    assign lim = ({4'b0000, idle_to_reg} << 3) + ({4'b0000, idle_to_reg} << 1);
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            ax_idle[i] = {1'b0, prev_time_reg - aat_reg[i]} > lim;
    end
    assign since_any = prev_time_reg - any_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg  <= DZ_W'(26);
            idle_to_reg    <= IDLE_W'(100000);
            finish_to_reg  <= T_W'(1000000);
            awaiting_reg   <= 1'b1;
            prev_time_reg  <= '0;
            any_time_reg   <= '0;
            cal_count_reg  <= '0;
            calibrated_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                aat_reg[i]   <= '0;
                vel_reg[i]   <= '0;
                pv_reg[i]    <= '0;
                pk_reg[i]    <= '0;
                bsum_reg[i]  <= '0;
                bmean_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DEAD_ZONE: dead_zone_reg <= cfg_data[DZ_W-1:0];
                    CFG_IDLE_TO:   idle_to_reg   <= cfg_data[IDLE_W-1:0];
                    CFG_FINISH_TO: finish_to_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (cmd.op == OP_LOAD_OUT)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;

            case (cmd.op)
                OP_LATCH:
                begin
                    if (func == FUNC_MOTION)
                        prev_time_reg <= time_us;
                end
                OP_CAL_ADD:
                begin
                    for (int i = 0; i < 3; i++)
                        bsum_reg[i] <= bsum_reg[i] + BSUM_W'(acc_reg[i]);
                    cal_count_reg <= cal_count_reg + 1'b1;
                end
                OP_DIV_DONE:
                begin
                    for (int i = 0; i < 3; i++)
                        bmean_reg[i] <= neg_reg[i] ? -qprod_reg[i][DIV_S +: ACC_W]
                                                   : qprod_reg[i][DIV_S +: ACC_W];
                    calibrated_reg <= 1'b1;
                end
                OP_FIRST:
                begin
                    awaiting_reg <= 1'b0;
                    for (int i = 0; i < 3; i++)
                        aat_reg[i] <= t_reg;
                    if (any_time_reg == '0)
                        any_time_reg <= t_reg;
                end
                OP_CLEAR:
                begin
                    awaiting_reg <= 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        vel_reg[i] <= '0;
                        pv_reg[i]  <= '0;
                        pk_reg[i]  <= '0;
                    end
                    if (func_reg == FUNC_FULL)
                    begin
                        prev_time_reg <= '0;
                        any_time_reg  <= '0;
                        for (int i = 0; i < 3; i++)
                            aat_reg[i] <= '0;
                    end
                end
                OP_ACCUM:
                begin
                    pv_reg[cmd.axis] <= sat50(pvsum);
                    pk_reg[cmd.axis] <= sat50(pksum);
                    if (anz_reg)
                    begin
                        aat_reg[cmd.axis] <= t_reg;
                        any_time_reg      <= t_reg;
                        vel_reg[cmd.axis] <= vn_reg;
                    end
                    else if (since_active > {3'b000, idle_to_reg})
                        vel_reg[cmd.axis] <= '0;
                    else
                        vel_reg[cmd.axis] <= vn_reg;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                func_reg   <= func;
                acc_reg[0] <= acc_x;
                acc_reg[1] <= acc_y;
                acc_reg[2] <= acc_z;
                t_reg      <= time_us;
                dt_reg     <= time_us - prev_time_reg;
            end
            OP_DIV_INIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= bsum_reg[i][BSUM_W-1];
                    num_reg[i] <= bsum_reg[i][BSUM_W-1] ? -bsum_reg[i] : bsum_reg[i];
                end
            end
            OP_DIV_STEP:
            begin
                for (int i = 0; i < 3; i++)
                    qprod_reg[i] <= QP_W'(num_reg[i]) * QP_W'(RECIP);
            end
            OP_MUL_AD:
            begin
                ad_reg  <= prod[AD_W-1:0];
                anz_reg <= (a_eff != '0);
            end
            OP_VEL:
            begin
                vn_reg   <= sat50(vsum);
                kacc_reg <= prod_w;
            end
            OP_K_HI: kacc_reg <= kacc_reg + (prod_w <<< 24);
            OP_V_LO: vacc_reg <= prod_w;
            OP_V_HI: vacc_reg <= vacc_reg + (prod_w <<< 24);
            OP_TERMS:
            begin
                t1_reg <= sat_wide(vacc_reg >>> POS_SHIFT);
                t2_reg <= sat_wide(ksum >>> (POS_SHIFT + 1));
            end
            OP_LOAD_OUT:
            begin
                pos_vel_x      <= pv_reg[0];
                pos_vel_y      <= pv_reg[1];
                pos_vel_z      <= pv_reg[2];
                pos_kin_x      <= pk_reg[0];
                pos_kin_y      <= pk_reg[1];
                pos_kin_z      <= pk_reg[2];
                all_axes_idle  <= &ax_idle;
                recording_done <= since_any > finish_to_reg;
                is_calibrated  <= calibrated_reg;
            end
            default: ;
        endcase
    end

    assign res_valid       = out_valid_reg;
    assign status.func     = func_reg;
    assign status.awaiting = awaiting_reg;
    assign status.cal_full = cal_count_reg >= CAL_N;
    assign status.cal_last = cal_count_reg == CAL_N - 1'b1;
    assign status.out_free = !out_valid_reg || res_ready;

endmodule

// File: hw/rtl/adri_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adri_ctrl
// Sequencer: dispatches each item and steps the datapath through its ops.
// ----------------------------------------------------------------------------
module adri_ctrl
    import adri_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_CAL      = 4'd2;
    localparam logic [3:0] S_DIV_INIT = 4'd3;
    localparam logic [3:0] S_DIV      = 4'd4;
    localparam logic [3:0] S_DIV_DONE = 4'd5;
    localparam logic [3:0] S_FIRST    = 4'd6;
    localparam logic [3:0] S_CLR      = 4'd7;
    localparam logic [3:0] S_MUL      = 4'd8;
    localparam logic [3:0] S_VEL      = 4'd9;
    localparam logic [3:0] S_KHI      = 4'd10;
    localparam logic [3:0] S_VLO      = 4'd11;
    localparam logic [3:0] S_VHI      = 4'd12;
    localparam logic [3:0] S_TERMS    = 4'd13;
    localparam logic [3:0] S_ACCUM    = 4'd14;
    localparam logic [3:0] S_FIN      = 4'd15;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd.op     = OP_NONE;
        cmd.axis   = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                axis_next = '0;
                unique case (status.func)
                    FUNC_CAL:    state_next = S_CAL;
                    FUNC_MOTION: state_next = status.awaiting ? S_FIRST : S_MUL;
                    default:     state_next = S_CLR;
                endcase
            end
            S_CAL:
            begin
                if (status.cal_full)
                    state_next = S_FIN;
                else
                begin
                    cmd.op     = OP_CAL_ADD;
                    state_next = status.cal_last ? S_DIV_INIT : S_FIN;
                end
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // reciprocal multiply
                cmd.op     = OP_DIV_STEP;
                state_next = S_DIV_DONE;
            end
            S_DIV_DONE:
            begin
                cmd.op     = OP_DIV_DONE;
                state_next = S_FIN;
            end
            S_FIRST:
            begin
                cmd.op     = OP_FIRST;
                state_next = S_FIN;
            end
            S_CLR:
            begin
                cmd.op     = OP_CLEAR;
                state_next = S_FIN;
            end
            S_MUL:
            begin
                cmd.op     = OP_MUL_AD;
                state_next = S_VEL;
            end
            S_VEL:
            begin
                cmd.op     = OP_VEL;
                state_next = S_KHI;
            end
            S_KHI:
            begin
                cmd.op     = OP_K_HI;
                state_next = S_VLO;
            end
            S_VLO:
            begin
                cmd.op     = OP_V_LO;
                state_next = S_VHI;
            end
            S_VHI:
            begin
                cmd.op     = OP_V_HI;
                state_next = S_TERMS;
            end
            S_TERMS:
            begin
                cmd.op     = OP_TERMS;
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                cmd.op = OP_ACCUM;
                if (axis_reg == 2'd2)
                    state_next = S_FIN;
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_FIN:
            begin
                // wait for the result register to free up
                if (status.out_free)
                begin
                    cmd.op     = OP_LOAD_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted beat not dispatched");

    a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && status.out_free) |=> (state_reg == S_IDLE))
        else $error("result load did not return to idle");

    a_div_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |=> (state_reg == S_DIV_DONE))
        else $error("bias multiply did not complete in one step");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACCUM && axis_reg == 2'd2) |=> (state_reg == S_FIN))
        else $error("axis sweep did not finish after last axis");

endmodule

// File: hw/rtl/accel_dead_reckoning_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_dead_reckoning_integrator
// Three-axis accelerometer bias removal, dead zone and dead-reckoning.
// ----------------------------------------------------------------------------
// Usage:
//   sample : valid/ready channel, one beat per item (func, acc_x/y/z, time_us).
//   result : valid/ready channel, one beat per item with both position
//            estimates per axis and the idle / done / calibrated flags.
//   cfg_*  : write port for dead_zone, idle_timeout_us, finish_timeout_us;
//            write only while the block is idle.
//   From sample beat to result valid, calibration, reset and first-motion
//   items go straight on to the final step; the calibration beat that completes
//   the bias first runs the reciprocal multiply; a motion item first steps the
//   single 25x33 multiplier shared over the three axes, one axis after another.
//   One item is in work at a time; the next sample is taken once the item's
//   result sits in the output register, even if the receiver has not taken it.
//   If the receiver stalls with a result still held, the next item waits
//   in its final step until the output register frees.
//   Reset clears all motion state, calibration and configuration to defaults.
// ----------------------------------------------------------------------------
module accel_dead_reckoning_integrator
    import adri_pkg::*;
#(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF,
    parameter int POS_SHIFT   = POS_SHIFT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    adri_in_if.sink               sample,
    adri_out_if.source            result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    adri_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .status   (status),
        .cmd      (cmd)
    );

    adri_datapath #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .POS_SHIFT   (POS_SHIFT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (sample.func),
        .acc_x          (sample.acc_x),
        .acc_y          (sample.acc_y),
        .acc_z          (sample.acc_z),
        .time_us        (sample.time_us),
        .res_valid      (result.valid),
        .res_ready      (result.ready),
        .pos_vel_x      (result.pos_vel_x),
        .pos_vel_y      (result.pos_vel_y),
        .pos_vel_z      (result.pos_vel_z),
        .pos_kin_x      (result.pos_kin_x),
        .pos_kin_y      (result.pos_kin_y),
        .pos_kin_z      (result.pos_kin_z),
        .all_axes_idle  (result.all_axes_idle),
        .recording_done (result.recording_done),
        .is_calibrated  (result.is_calibrated)
    );

endmodule

// File: test/adri_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adri_result_checker
// Watches the sample, result and register-write traffic of the dead-reckoning
// integrator, keeps its own copy of the integrator state, predicts every
// result beat and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module adri_result_checker
    import adri_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    adri_in_if                    smp,
    adri_out_if                   res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    localparam int NUM_CAL = CAL_SAMPLES_DEF;
    localparam int SHIFT   = POS_SHIFT_DEF;

    typedef struct packed {
        logic [2:0][47:0] pv;
        logic [2:0][47:0] pk;
        logic             idle;
        logic             done;
        logic             cal;
    } track_t;

    // register copies
    logic [14:0] dz;
    logic [28:0] idle_to;
    logic [31:0] finish_to;

    // integrator state copy
    logic               first_pending;
    logic [31:0]        last_t;
    logic [31:0]        axis_t [3];
    logic [31:0]        any_t;
    logic signed [47:0] vel [3];
    logic signed [47:0] pvel [3];
    logic signed [47:0] pkin [3];
    logic signed [31:0] bsum [3];
    logic signed [31:0] bmean [3];
    int                 ncal;
    logic               have_bias;

    track_t track_q[$];
    int     n_fail = 0;

    assign errors  = n_fail;
    assign pending = track_q.size();

    function automatic logic signed [47:0] clamp48(input logic signed [127:0] v);
        if (v > 128'sd140737488355327)
            return 48'sh7FFF_FFFF_FFFF;
        if (v < -128'sd140737488355328)
            return 48'sh8000_0000_0000;
        return v[47:0];
    endfunction

    task automatic clear_motion();
        first_pending = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            vel[i]  = '0;
            pvel[i] = '0;
            pkin[i] = '0;
        end
    endtask

    task automatic reset_state();
        dz        = 15'd26;
        idle_to   = 29'd100000;
        finish_to = 32'd1000000;
        clear_motion();
        last_t    = '0;
        any_t     = '0;
        for (int i = 0; i < 3; i++)
        begin
            axis_t[i] = '0;
            bsum[i]   = '0;
            bmean[i]  = '0;
        end
        ncal      = 0;
        have_bias = 1'b0;
    endtask

    task automatic integrate(input logic signed [15:0] acc [3], input logic [31:0] t);
        logic [31:0]         dt;
        logic signed [31:0]  a;
        logic [31:0]         mag;
        logic signed [127:0] a_w, dt_w, v_w, prod;
        dt     = t - last_t;
        last_t = t;
        if (first_pending)
        begin
            first_pending = 1'b0;
            for (int i = 0; i < 3; i++)
                axis_t[i] = t;
            if (any_t == 0)
                any_t = t;
            return;
        end
        dt_w = $signed({96'd0, dt});
        for (int i = 0; i < 3; i++)
        begin
            a   = 32'(acc[i]) - bmean[i];
            mag = (a < 0) ? -a : a;
            if (mag < {17'd0, dz})
                a = 0;
            a_w    = a;
            v_w    = vel[i];
            vel[i] = clamp48(v_w + a_w * dt_w);
            v_w    = vel[i];
            prod   = (v_w * dt_w) >>> SHIFT;
            v_w    = pvel[i];
            pvel[i] = clamp48(v_w + 128'(clamp48(prod)));
            v_w    = vel[i];
            prod   = (a_w * dt_w * dt_w + (v_w <<< 1) * dt_w) >>> (SHIFT + 1);
            v_w    = pkin[i];
            pkin[i] = clamp48(v_w + 128'(clamp48(prod)));
            if (a != 0)
            begin
                axis_t[i] = t;
                any_t     = t;
            end
            else if ((t - axis_t[i]) > {3'd0, idle_to})
                vel[i] = '0;
        end
    endtask

    task automatic apply_item();
        logic signed [15:0] acc [3];
        acc[0] = smp.acc_x;
        acc[1] = smp.acc_y;
        acc[2] = smp.acc_z;
        case (smp.func)
            FUNC_CAL:
            begin
                if (ncal < NUM_CAL)
                begin
                    for (int i = 0; i < 3; i++)
                        bsum[i] = bsum[i] + 32'(acc[i]);
                    ncal++;
                    if (ncal == NUM_CAL)
                    begin
                        for (int i = 0; i < 3; i++)
                            bmean[i] = bsum[i] / NUM_CAL;
                        have_bias = 1'b1;
                    end
                end
            end
            FUNC_MOTION: integrate(acc, smp.time_us);
            FUNC_SOFT: clear_motion();
            default:
            begin
                clear_motion();
                last_t = '0;
                any_t  = '0;
                for (int i = 0; i < 3; i++)
                    axis_t[i] = '0;
            end
        endcase
    endtask

    function automatic track_t snapshot();
        track_t      s;
        logic [63:0] lim;
        lim    = 64'(idle_to) * 64'd10;
        s.idle = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            s.pv[i] = pvel[i];
            s.pk[i] = pkin[i];
            if ({32'd0, last_t - axis_t[i]} <= lim)
                s.idle = 1'b0;
        end
        s.done = (last_t - any_t) > finish_to;
        s.cal  = have_bias;
        return s;
    endfunction

    task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
        $display("MISMATCH %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        n_fail++;
    endtask

    task automatic check_beat();
        track_t want;
        if (track_q.size() == 0)
        begin
            $display("MISMATCH %0t: result beat with nothing outstanding", $realtime);
            n_fail++;
            return;
        end
        want = track_q.pop_front();
        if (res.pos_vel_x !== want.pv[0]) report("pos_vel_x", res.pos_vel_x, want.pv[0]);
        if (res.pos_vel_y !== want.pv[1]) report("pos_vel_y", res.pos_vel_y, want.pv[1]);
        if (res.pos_vel_z !== want.pv[2]) report("pos_vel_z", res.pos_vel_z, want.pv[2]);
        if (res.pos_kin_x !== want.pk[0]) report("pos_kin_x", res.pos_kin_x, want.pk[0]);
        if (res.pos_kin_y !== want.pk[1]) report("pos_kin_y", res.pos_kin_y, want.pk[1]);
        if (res.pos_kin_z !== want.pk[2]) report("pos_kin_z", res.pos_kin_z, want.pk[2]);
        if (res.all_axes_idle !== want.idle)
            report("all_axes_idle", 48'(res.all_axes_idle), 48'(want.idle));
        if (res.recording_done !== want.done)
            report("recording_done", 48'(res.recording_done), 48'(want.done));
        if (res.is_calibrated !== want.cal)
            report("is_calibrated", 48'(res.is_calibrated), 48'(want.cal));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_state();
            track_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEAD_ZONE: dz        = cfg_data[14:0];
                    CFG_IDLE_TO:   idle_to   = cfg_data[28:0];
                    CFG_FINISH_TO: finish_to = cfg_data;
                    default: ;
                endcase
            end
            if (res.valid && res.ready)
                check_beat();
            if (smp.valid && smp.ready)
            begin
                apply_item();
                track_q.push_back(snapshot());
            end
        end
    end

endmodule

// File: test/tb_accel_dead_reckoning_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_dead_reckoning_integrator
// Drives calibration, motion and reset beats through the integrator over
// several register settings, with random gaps and receiver stalls; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_accel_dead_reckoning_integrator;
    import adri_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  no_gaps;
    logic                  stall_req;
    logic                  stall_done;
    int                    stall_left;
    int                    errors;
    int                    pending;
    int                    cycles;
    logic [31:0]           now_us;

    adri_in_if  smp();
    adri_out_if res();

    accel_dead_reckoning_integrator DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp),
        .result    (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    adri_result_checker u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp       (smp),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready  <= 1'b0;
            stall_left <= 0;
            stall_done <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            res.ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_req && !stall_done)
        begin
            res.ready  <= 1'b0;
            stall_left <= 400;
            stall_done <= 1'b1;
        end
        else
            res.ready <= no_gaps || ($urandom_range(99) >= 27);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("accel_dead_reckoning_integrator verification failed");
            $finish;
        end
    end

    task automatic send(input logic [1:0] fn, input logic [15:0] ax, input logic [15:0] ay,
                        input logic [15:0] az, input logic [31:0] t);
        while (!no_gaps && $urandom_range(99) < 27)
        begin
            smp.valid <= 1'b0;
            @(posedge clk);
        end
        smp.valid   <= 1'b1;
        smp.func    <= fn;
        smp.acc_x   <= ax;
        smp.acc_y   <= ay;
        smp.acc_z   <= az;
        smp.time_us <= t;
        @(posedge clk);
        while (!smp.ready)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_acc();
        case ($urandom_range(9))
            0, 1, 2, 3: return 16'($signed($urandom_range(120)) - 60);
            4, 5, 6:    return 16'($signed($urandom_range(4000)) - 2000);
            7:          return 16'($urandom);
            8:          return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default:    return 16'h0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_dt();
        case ($urandom_range(19))
            0:                  return 32'd0;
            1, 2, 3, 4, 5, 6,
            7, 8, 9, 10, 11:    return $urandom_range(4000, 1);
            12, 13, 14, 15:     return $urandom_range(300000);
            16, 17, 18:         return $urandom_range(1 << 24);
            default:            return $urandom;
        endcase
    endfunction

    task automatic motion(input logic [31:0] dt, input logic [15:0] ax, input logic [15:0] ay,
                          input logic [15:0] az);
        now_us = now_us + dt;
        send(FUNC_MOTION, ax, ay, az, now_us);
    endtask

    task automatic settle();
        smp.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int n_items);
        int done_items;
        int r;
        int len;
        done_items = 0;
        while (done_items < n_items)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                len = $urandom_range(20, 1);
                for (int i = 0; i < len; i++)
                    motion(pick_dt(), pick_acc(), pick_acc(), pick_acc());
                done_items += len;
            end
            else if (r < 78)
            begin
                send(FUNC_SOFT, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
                done_items++;
            end
            else if (r < 84)
            begin
                send(FUNC_FULL, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
                if ($urandom_range(1))
                    now_us = $urandom;
                done_items++;
            end
            else if (r < 88)
            begin
                send(FUNC_CAL, pick_acc(), pick_acc(), pick_acc(), $urandom);
                done_items++;
            end
            else
            begin
                send(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
                done_items++;
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cycles     = 0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_DEAD_ZONE;
        cfg_data   = '0;
        no_gaps    = 1'b0;
        stall_req  = 1'b0;
        smp.valid  = 1'b0;
        smp.func   = FUNC_CAL;
        smp.acc_x  = '0;
        smp.acc_y  = '0;
        smp.acc_z  = '0;
        smp.time_us = '0;
        now_us     = $urandom;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first sample latches, uncalibrated extremes, wrap, resets
        motion(32'd0, 16'h0000, 16'h0000, 16'h0000);
        motion(32'd1000, 16'h7FFF, 16'h8000, 16'h0019);
        motion(32'd1000, 16'h8000, 16'h7FFF, 16'hFFE6);
        motion(32'hFFFF_FFF0, 16'h7FFF, 16'h7FFF, 16'h8000);
        motion(32'd500000, 16'h0000, 16'h0000, 16'h0000);
        send(FUNC_CAL, 16'h7FFF, 16'h8000, 16'h0000, 32'hFFFF_FFFF);
        send(FUNC_CAL, 16'h8000, 16'h7FFF, 16'hFFFF, 32'h0000_0000);
        send(FUNC_SOFT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        motion(32'd10, 16'h0100, 16'h0100, 16'h0100);
        motion(32'd10, 16'h0100, 16'hFF00, 16'h0000);
        send(FUNC_FULL, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
        motion(32'd7, 16'h0040, 16'h0000, 16'hFFC0);
        motion(32'd2000000, 16'h0000, 16'h0000, 16'h0000);

        // finish the bias, then a few extra calibration beats that are ignored
        for (int i = 0; i < 22; i++)
            send(FUNC_CAL, 16'($signed($urandom_range(6000)) - 3000),
                 16'($signed($urandom_range(6000)) - 3000),
                 16'($signed($urandom_range(6000)) - 3000), $urandom);
        run_phase(100);

        settle();
        write_reg(CFG_DEAD_ZONE, 32'd0);
        write_reg(CFG_IDLE_TO, 32'd0);
        write_reg(CFG_FINISH_TO, 32'd0);
        no_gaps <= 1'b1;
        run_phase(110);
        settle();
        no_gaps <= 1'b0;

        write_reg(CFG_DEAD_ZONE, 32'h7FFF);
        write_reg(CFG_IDLE_TO, 32'd400000000);
        write_reg(CFG_FINISH_TO, 32'hFFFF_FFFF);
        stall_req <= 1'b1;
        run_phase(110);
        settle();

        write_reg(CFG_DEAD_ZONE, $urandom_range(200));
        write_reg(CFG_IDLE_TO, $urandom_range(300000, 1000));
        write_reg(CFG_FINISH_TO, $urandom_range(2000000));
        run_phase(110);
        settle();

        write_reg(CFG_DEAD_ZONE, 32'd26);
        write_reg(CFG_IDLE_TO, 32'd100000);
        write_reg(CFG_FINISH_TO, 32'd1000000);
        run_phase(110);
        settle();

        write_reg(CFG_DEAD_ZONE, $urandom_range(32767));
        write_reg(CFG_IDLE_TO, $urandom_range(400000000));
        write_reg(CFG_FINISH_TO, $urandom);
        run_phase(110);
        settle();

        if (errors == 0)
            $display("accel_dead_reckoning_integrator verification clean");
        else
            $display("accel_dead_reckoning_integrator verification failed");
        $finish;
    end

endmodule
